// File: src/ring_buffer_deque_top_assert.svh
// Assertion macros for the ring buffer deque checker.
`ifndef RING_BUFFER_DEQUE_TOP_ASSERT_SVH
`define RING_BUFFER_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define RBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define RBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbd check failed: next-cycle implication");

`endif

// File: src/rbd_pkg.sv
package rbd_pkg;

    // Defaults for the top-level parameters.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths.
    localparam int KIND_W      = 4;
    localparam int DIN_W       = 32;
    localparam int DOUT_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int OUT_TDATA_W = ((DOUT_W + 1 + STATUS_W + COUNT_W + 7) / 8) * 8;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 4'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 4'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 4'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK_FRONT = 4'd4;
    localparam logic [KIND_W-1:0] KIND_PEEK_BACK  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RM_FIRST   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_RM_LAST    = 4'd7;
    localparam logic [KIND_W-1:0] KIND_CONTAINS   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_CLEAR      = 4'd9;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DIN_W-1:0]  data;
    } t_req;

    typedef struct packed {
        logic [DOUT_W-1:0]   data;
        logic                hit;
        logic [STATUS_W-1:0] status;
    } t_res;

    // Top -> sequencer.
    typedef struct packed {
        logic start;
        logic res_taken;
    } t_ctl_cmd;

    // Sequencer -> top.
    typedef struct packed {
        logic ready;
        logic res_valid;
    } t_ctl_stat;

endpackage

// File: src/ring_buffer_deque_top.sv
// Ring buffer deque: DEPTH words kept in a ring memory with front/back
// pointers and an entry count.
// Input channel (i_s_*): one request per transaction. tuser carries the
// request kind, tdata the value pushed or searched for.
// Output channel (o_m_*): exactly one result transaction per request,
// in request order, held in an output register.
// Sequencer states from the accept until ready again (S_DONE holds
// until the result is taken): push, clear, unused kinds S_EXEC, S_DONE;
// pop / peek S_EXEC, S_PEEK (one memory read), S_DONE; contains / remove
// S_EXEC, then S_SCAN_RD, S_SCAN_CMP per entry examined and S_MOVE_RD,
// S_MOVE_WR per entry moved to close the gap, then S_DONE.
// The memory has one read and one write port; each scan step and each
// shift step is a read followed by compare or write, run by one sequencer.
// A gap is closed from the shorter side, so at most DEPTH/2 entries move.
// o_s_tready is high only while the sequencer is idle; one request is in
// work at a time.
// A result waits in the sequencer while the output register holds an
// untaken transaction; nothing is dropped when the receiver stalls.
// Synchronous active-low reset empties the deque (pointers and count to
// zero) and clears the output valid; memory contents are not cleared.
module ring_buffer_deque_top #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [rbd_pkg::DIN_W-1:0]        i_s_tdata,   // [31:0] data_in
    input  logic [rbd_pkg::KIND_W-1:0]       i_s_tuser,   // [3:0] kind
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] data_out, [32] hit, [34:33] status, [39:35] count
    output logic [rbd_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import rbd_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_ctl_cmd              w_cmd;
    t_ctl_stat             w_stat;
    t_req                  w_req;
    t_res                  w_res;
    logic [CW-1:0]         w_count;
    logic [COUNT_W-1:0]    w_count_out;
    logic                  w_mem_we;
    logic [IW-1:0]         w_mem_waddr;
    logic [DATA_WIDTH-1:0] w_mem_wdata;
    logic [IW-1:0]         w_mem_raddr;
    logic [DATA_WIDTH-1:0] w_mem_rdata;

    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    // Output register is free when empty or being drained this cycle.
    assign o_s_tready    = w_stat.ready;
    assign w_cmd.start   = i_s_tvalid && w_stat.ready;
    assign w_cmd.res_taken = w_stat.res_valid && (!r_m_tvalid || i_m_tready);
    assign w_req.kind    = i_s_tuser;
    assign w_req.data    = i_s_tdata;

    generate
        if (CW >= COUNT_W) begin : g_cnt_cut
            assign w_count_out = w_count[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign w_count_out = {{(COUNT_W - CW){1'b0}}, w_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_cmd.res_taken) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
        if (w_cmd.res_taken) begin
            r_m_tdata <= {w_count_out, w_res.status, w_res.hit, w_res.data};
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    rbd_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (w_req),
        .o_stat      (w_stat),
        .o_res       (w_res),
        .o_count     (w_count),
        .o_mem_we    (w_mem_we),
        .o_mem_waddr (w_mem_waddr),
        .o_mem_wdata (w_mem_wdata),
        .o_mem_raddr (w_mem_raddr),
        .i_mem_rdata (w_mem_rdata)
    );

    rbd_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

// File: src/rbd_mem.sv
module rbd_mem #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
    localparam int IW        = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [IW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic [IW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);
    import rbd_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/rbd_ctrl.sv
module rbd_ctrl #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF,
    localparam int IW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rbd_pkg::t_ctl_cmd     i_cmd,
    input  rbd_pkg::t_req         i_req,
    output rbd_pkg::t_ctl_stat    o_stat,
    output rbd_pkg::t_res         o_res,
    output logic [CW-1:0]         o_count,
    output logic                  o_mem_we,
    output logic [IW-1:0]         o_mem_waddr,
    output logic [DATA_WIDTH-1:0] o_mem_wdata,
    output logic [IW-1:0]         o_mem_raddr,
    input  logic [DATA_WIDTH-1:0] i_mem_rdata
);
    import rbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PEEK,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_DONE
    } t_state;

    t_state                r_state, n_state;
    logic [KIND_W-1:0]     r_kind, n_kind;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [IW-1:0]         r_front, n_front;
    logic [IW-1:0]         r_back, n_back;
    logic [CW-1:0]         r_count, n_count;
    logic [IW-1:0]         r_k, n_k;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_front_side, n_front_side;
    logic [DOUT_W-1:0]     r_res_data, n_res_data;
    logic                  r_res_hit, n_res_hit;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;

    logic [DATA_WIDTH-1:0] w_din;
    logic [DOUT_W-1:0]     w_rd_ext;
    logic [IW-1:0]         w_off;
    logic [IW-1:0]         w_slot;
    logic [CW-1:0]         w_pos;
    logic [CW-1:0]         w_cnt_m1;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_match;
    logic                  w_fwd_scan;

    generate
        if (DATA_WIDTH >= DIN_W) begin : g_din_ext
            assign w_din = DATA_WIDTH'(i_req.data);
        end else begin : g_din_cut
            assign w_din = i_req.data[DATA_WIDTH-1:0];
        end
        if (DATA_WIDTH >= DOUT_W) begin : g_dout_cut
            assign w_rd_ext = i_mem_rdata[DOUT_W-1:0];
        end else begin : g_dout_ext
            assign w_rd_ext = {{(DOUT_W - DATA_WIDTH){1'b0}}, i_mem_rdata};
        end
    endgenerate

    // Shared slot adder and comparator.
    assign w_slot     = r_front + w_off;
    assign w_pos      = CW'(r_k);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_match    = (i_mem_rdata == r_val);
    assign w_fwd_scan = (r_kind != KIND_RM_LAST);

    always_comb begin
        case (r_state)
            S_MOVE_RD: w_off = r_front_side ? (r_k - IW'(1)) : (r_k + IW'(1));
            default:   w_off = r_k;
        endcase
    end

    // Memory port control.
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_back;
        o_mem_wdata = r_val;
        o_mem_raddr = w_slot;
        case (r_state)
            S_EXEC: begin
                if (r_kind == KIND_PUSH_FRONT) begin
                    o_mem_we    = !w_full;
                    o_mem_waddr = r_front - IW'(1);
                end else if (r_kind == KIND_PUSH_BACK) begin
                    o_mem_we    = !w_full;
                end
                if (r_kind == KIND_POP_BACK || r_kind == KIND_PEEK_BACK) begin
                    o_mem_raddr = r_back - IW'(1);
                end else begin
                    o_mem_raddr = r_front;
                end
            end
            S_MOVE_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = w_slot;
                o_mem_wdata = i_mem_rdata;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_val        = r_val;
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        n_k          = r_k;
        n_left       = r_left;
        n_front_side = r_front_side;
        n_res_data   = r_res_data;
        n_res_hit    = r_res_hit;
        n_res_status = r_res_status;
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_kind       = i_req.kind;
                    n_val        = w_din;
                    n_res_data   = '0;
                    n_res_hit    = 1'b0;
                    n_res_status = ST_OK;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_kind)
                    KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_count = r_count + CW'(1);
                            if (r_kind == KIND_PUSH_FRONT) begin
                                n_front = r_front - IW'(1);
                            end else begin
                                n_back = r_back + IW'(1);
                            end
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_BACK, KIND_PEEK_FRONT, KIND_PEEK_BACK: begin
                        if (w_empty) begin
                            n_res_status = ST_EMPTY;
                        end else begin
                            n_state = S_PEEK;
                        end
                    end
                    KIND_RM_FIRST, KIND_RM_LAST, KIND_CONTAINS: begin
                        if (!w_empty) begin
                            n_left  = r_count;
                            n_k     = w_fwd_scan ? '0 : w_cnt_m1[IW-1:0];
                            n_state = S_SCAN_RD;
                        end
                    end
                    KIND_CLEAR: begin
                        n_front = '0;
                        n_back  = '0;
                        n_count = '0;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_PEEK: begin
                n_res_data = w_rd_ext;
                n_res_hit  = 1'b1;
                n_state    = S_DONE;
                if (r_kind == KIND_POP_FRONT) begin
                    n_front = r_front + IW'(1);
                    n_count = w_cnt_m1;
                end else if (r_kind == KIND_POP_BACK) begin
                    n_back  = r_back - IW'(1);
                    n_count = w_cnt_m1;
                end
            end
            S_SCAN_RD: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                if (w_match) begin
                    n_res_hit = 1'b1;
                    if (r_kind == KIND_CONTAINS) begin
                        n_state = S_DONE;
                    end else if (w_pos < (r_count - w_pos)) begin
                        // close the gap from the front side
                        n_front_side = 1'b1;
                        if (r_k == '0) begin
                            n_front = r_front + IW'(1);
                            n_count = w_cnt_m1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_MOVE_RD;
                        end
                    end else begin
                        n_front_side = 1'b0;
                        if ((w_pos + CW'(1)) >= r_count) begin
                            n_back  = r_back - IW'(1);
                            n_count = w_cnt_m1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_MOVE_RD;
                        end
                    end
                end else if (r_left == CW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_left  = r_left - CW'(1);
                    n_k     = w_fwd_scan ? (r_k + IW'(1)) : (r_k - IW'(1));
                    n_state = S_SCAN_RD;
                end
            end
            S_MOVE_RD: begin
                n_state = S_MOVE_WR;
            end
            S_MOVE_WR: begin
                n_state = S_MOVE_RD;
                if (r_front_side) begin
                    n_k = r_k - IW'(1);
                    if (r_k == IW'(1)) begin
                        n_front = r_front + IW'(1);
                        n_count = w_cnt_m1;
                        n_state = S_DONE;
                    end
                end else begin
                    n_k = r_k + IW'(1);
                    if ((w_pos + CW'(2)) >= r_count) begin
                        n_back  = r_back - IW'(1);
                        n_count = w_cnt_m1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_cmd.res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
        r_kind       <= n_kind;
        r_val        <= n_val;
        r_k          <= n_k;
        r_left       <= n_left;
        r_front_side <= n_front_side;
        r_res_data   <= n_res_data;
        r_res_hit    <= n_res_hit;
        r_res_status <= n_res_status;
    end

    assign o_stat.ready     = (r_state == S_IDLE);
    assign o_stat.res_valid = (r_state == S_DONE);
    assign o_res.data       = r_res_data;
    assign o_res.hit        = r_res_hit;
    assign o_res.status     = r_res_status;
    assign o_count          = r_count;

endmodule

// File: src/rbd_checker.sv
`include "ring_buffer_deque_top_assert.svh"

module rbd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rbd_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import rbd_pkg::*;

    // Stalled result transaction holds.
    `RBD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // One request in work at a time: not ready right after an accept.
    `RBD_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // Empty or full status never carries a hit or data.
    `RBD_ASSERT_IMP(a_status_no_hit, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[34:33] != ST_OK), !o_m_tdata[32] && (o_m_tdata[31:0] == '0))

    // Status is one of the defined codes.
    `RBD_ASSERT_IMP(a_status_code, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata[34:33] == ST_OK) || (o_m_tdata[34:33] == ST_EMPTY) || (o_m_tdata[34:33] == ST_FULL))

endmodule

bind ring_buffer_deque_top rbd_checker u_rbd_checker (.*);
